[rtl/cbe_pkg.sv]
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared types and constants of the cubic Bezier easing block: default
// sizes, register indexes, the datapath operation codes and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package cbe_pkg;

  // Default sizes.
  localparam int DEF_FRAC_BITS    = 16;
  localparam int DEF_NEWTON_STEPS = 8;
  localparam int DEF_BISECT_STEPS = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_X1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y2 = 3'd3;

  // Datapath operations, one per cycle.
  typedef enum logic [4:0] {
    OP_NOP        = 5'd0,
    OP_LOAD       = 5'd1,
    OP_EVAL_S     = 5'd2,
    OP_EVAL_MID   = 5'd3,
    OP_M_A        = 5'd4,
    OP_M_B        = 5'd5,
    OP_M_C        = 5'd6,
    OP_M_B1       = 5'd7,
    OP_M_B2       = 5'd8,
    OP_M_B3       = 5'd9,
    OP_M_P1       = 5'd10,
    OP_M_P2       = 5'd11,
    OP_SUM        = 5'd12,
    OP_M_D1       = 5'd13,
    OP_M_D2       = 5'd14,
    OP_M_D3       = 5'd15,
    OP_DSUM       = 5'd16,
    OP_DIV_START  = 5'd17,
    OP_DIV_STEP   = 5'd18,
    OP_NEWTON_UPD = 5'd19,
    OP_BIS        = 5'd20,
    OP_SAVE_N     = 5'd21,
    OP_PICK       = 5'd22,
    OP_OUT        = 5'd23
  } op_t;

  // Command from controller to datapath.
  typedef struct packed {
    op_t  op;
    logic sel_y;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic t_clamp;
    logic dx_zero;
    logic div_done;
  } dp_stat_t;

endpackage

[rtl/cbe_datapath.sv]
// ----------------------------------------------------------------------------
// cbe_datapath
// Fixed-point datapath: one shared rounding multiplier, the Bernstein sums,
// a radix-2 restoring divider for the Newton step and the bisection bounds.
// ----------------------------------------------------------------------------
module cbe_datapath #(
  parameter int FRAC_BITS = cbe_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cbe_pkg::dp_cmd_t               cmd,
  output cbe_pkg::dp_stat_t              stat,
  input  logic signed [FRAC_BITS+2:0]    progress,
  input  logic        [FRAC_BITS:0]      ctrl_x1,
  input  logic signed [FRAC_BITS+2:0]    ctrl_y1,
  input  logic        [FRAC_BITS:0]      ctrl_x2,
  input  logic signed [FRAC_BITS+2:0]    ctrl_y2,
  output logic signed [FRAC_BITS+2:0]    eased,
  output logic                           done
);
  import cbe_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int XW = F + 1;
  localparam int YW = F + 3;
  localparam int OW = F + 4;
  localparam int AW = F + 6;
  localparam int NW = AW + 1 + F;
  localparam int SW = NW + 2;
  localparam int CW = $clog2(NW + 1);
  localparam logic [XW-1:0] ONE_X = XW'(1) << F;
  localparam logic signed [YW-1:0] ONE_Y = YW'(1) << F;
  localparam logic signed [YW-1:0] Y_MIN = -(ONE_Y <<< 1);
  localparam logic signed [YW-1:0] Y_MAX = (ONE_Y <<< 1) + ONE_Y;
  localparam logic [2*OW-1:0] HALF = (2*OW)'(1) << (F - 1);

  // Registers.
  logic signed [YW-1:0] t;
  logic                 t_le0;
  logic                 t_clamp;
  logic [XW-1:0]        s, lo, hi, e;
  logic signed [OW-1:0] pa, pb, pc, pb1, pb2, pb3, pm1, pm2, pm3;
  logic signed [AW-1:0] acc, dx;
  logic [AW:0]          xn_err;
  logic [AW-1:0]        rem, den;
  logic [NW-1:0]        quo;
  logic [CW-1:0]        dcnt;
  logic                 dneg;

  // Clamped control points.
  logic [XW-1:0]        x1c, x2c;
  logic signed [OW-1:0] x1s, x2s, y1s, y2s, dxx, omx2;
  logic signed [YW-1:0] y1c, y2c;

  always_comb begin
    x1c = (ctrl_x1 > ONE_X) ? ONE_X : ctrl_x1;
    x2c = (ctrl_x2 > ONE_X) ? ONE_X : ctrl_x2;
    y1c = (ctrl_y1 < Y_MIN) ? Y_MIN : ((ctrl_y1 > Y_MAX) ? Y_MAX : ctrl_y1);
    y2c = (ctrl_y2 < Y_MIN) ? Y_MIN : ((ctrl_y2 > Y_MAX) ? Y_MAX : ctrl_y2);
    x1s = $signed({{(OW-XW){1'b0}}, x1c});
    x2s = $signed({{(OW-XW){1'b0}}, x2c});
    y1s = OW'(y1c);
    y2s = OW'(y2c);
    dxx = x2s - x1s;
    omx2 = $signed({{(OW-XW){1'b0}}, ONE_X}) - x2s;
  end

  // Shared multiplier operands.
  logic signed [OW-1:0] e_s, inv_s, ma, mb, mr;
  logic [OW-1:0]        amag, bmag;
  logic [2*OW-1:0]      prod, rnd;
  logic [OW-1:0]        rmag;
  logic                 mneg;

  always_comb begin
    e_s   = $signed({{(OW-XW){1'b0}}, e});
    inv_s = $signed({{(OW-XW){1'b0}}, ONE_X - e});
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_M_A:  begin ma = inv_s; mb = inv_s; end
      OP_M_B:  begin ma = inv_s; mb = e_s; end
      OP_M_C:  begin ma = e_s;   mb = e_s; end
      OP_M_B1: begin ma = pa;    mb = e_s; end
      OP_M_B2: begin ma = pb;    mb = e_s; end
      OP_M_B3: begin ma = pc;    mb = e_s; end
      OP_M_P1: begin ma = pb1;   mb = cmd.sel_y ? y1s : x1s; end
      OP_M_P2: begin ma = pb2;   mb = cmd.sel_y ? y2s : x2s; end
      OP_M_D1: begin ma = pa;    mb = x1s; end
      OP_M_D2: begin ma = pb;    mb = dxx; end
      OP_M_D3: begin ma = pc;    mb = omx2; end
      default: begin ma = '0;    mb = '0; end
    endcase
  end

  // Product rounded to nearest, ties away from zero.
  always_comb begin
    mneg = ma[OW-1] ^ mb[OW-1];
    amag = ma[OW-1] ? OW'(-ma) : OW'(ma);
    bmag = mb[OW-1] ? OW'(-mb) : OW'(mb);
    prod = (2*OW)'(amag) * (2*OW)'(bmag);
    rnd  = prod + HALF;
    rmag = OW'(rnd >> F);
    mr   = mneg ? -$signed(rmag) : $signed(rmag);
  end

  // Bernstein sums and error terms.
  logic signed [AW-1:0] e1, e2, e3, sum_b, sum_d, t_ext;
  logic signed [AW:0]   diff;
  logic [AW:0]          err;

  always_comb begin
    e1 = AW'(pm1);
    e2 = AW'(pm2);
    e3 = AW'(pm3);
    sum_b = e1 + (e1 <<< 1) + e2 + (e2 <<< 1) + AW'(pb3);
    sum_d = e1 + (e1 <<< 1) + (e2 <<< 1) + (e2 <<< 2) + e3 + (e3 <<< 1);
    t_ext = AW'(t);
    diff  = (AW+1)'(acc) - (AW+1)'(t_ext);
    err   = diff[AW] ? (AW+1)'(-diff) : (AW+1)'(diff);
  end

  // Divider step and Newton update.
  logic [AW:0]          trial;
  logic                 qbit;
  logic signed [SW-1:0] q_ext, s_new;

  always_comb begin
    trial = {rem, quo[NW-1]};
    qbit  = (trial >= {1'b0, den});
    q_ext = $signed({2'b00, quo});
    if (dneg) begin
      q_ext = -q_ext;
    end
    s_new = $signed({{(SW-XW){1'b0}}, s}) - q_ext;
  end

  // Control registers of the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      done    <= 1'b0;
      t_clamp <= 1'b0;
      t_le0   <= 1'b0;
      dcnt    <= '0;
    end else begin
      done <= (cmd.op == OP_OUT);
      if (cmd.op == OP_LOAD) begin
        t_le0   <= (progress <= 0);
        t_clamp <= (progress <= 0) || (progress >= ONE_Y);
      end
      if (cmd.op == OP_DIV_START) begin
        dcnt <= '0;
      end else if (cmd.op == OP_DIV_STEP) begin
        dcnt <= dcnt + 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        t  <= progress;
        s  <= progress[XW-1:0];
        lo <= '0;
        hi <= ONE_X;
      end
      OP_EVAL_S:   e <= s;
      OP_EVAL_MID: e <= XW'(({1'b0, lo} + {1'b0, hi}) >> 1);
      OP_M_A:  pa  <= mr;
      OP_M_B:  pb  <= mr;
      OP_M_C:  pc  <= mr;
      OP_M_B1: pb1 <= mr;
      OP_M_B2: pb2 <= mr;
      OP_M_B3: pb3 <= mr;
      OP_M_P1: pm1 <= mr;
      OP_M_P2: pm2 <= mr;
      OP_M_D1: pm1 <= mr;
      OP_M_D2: pm2 <= mr;
      OP_M_D3: pm3 <= mr;
      OP_SUM:  acc <= sum_b;
      OP_DSUM: dx  <= sum_d;
      OP_DIV_START: begin
        dneg <= diff[AW] ^ dx[AW-1];
        quo  <= {err, {F{1'b0}}};
        den  <= dx[AW-1] ? AW'(-dx) : AW'(dx);
        rem  <= '0;
      end
      OP_DIV_STEP: begin
        rem <= qbit ? AW'(trial - {1'b0, den}) : trial[AW-1:0];
        quo <= {quo[NW-2:0], qbit};
      end
      OP_NEWTON_UPD: begin
        if (s_new < 0) begin
          s <= '0;
        end else if (s_new > $signed({{(SW-XW){1'b0}}, ONE_X})) begin
          s <= ONE_X;
        end else begin
          s <= s_new[XW-1:0];
        end
      end
      OP_BIS: begin
        if (acc < t_ext) begin
          lo <= e;
        end else begin
          hi <= e;
        end
      end
      OP_SAVE_N: xn_err <= err;
      OP_PICK: begin
        if (!(xn_err < err)) begin
          s <= e;
        end
      end
      OP_OUT: begin
        if (t_le0) begin
          eased <= '0;
        end else if (t_clamp) begin
          eased <= ONE_Y;
        end else if (acc < AW'(Y_MIN)) begin
          eased <= Y_MIN;
        end else if (acc > AW'(Y_MAX)) begin
          eased <= Y_MAX;
        end else begin
          eased <= acc[YW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Status back to the controller.
  always_comb begin
    stat.t_clamp  = t_clamp;
    stat.dx_zero  = (dx == '0);
    stat.div_done = (dcnt == CW'(NW));
  end

endmodule

[rtl/cbe_ctrl.sv]
// ----------------------------------------------------------------------------
// cbe_ctrl
// Controller: sequences the Newton steps, the bisection steps, the choice
// between the two answers and the final y evaluation, one datapath
// operation per cycle.
// ----------------------------------------------------------------------------
module cbe_ctrl #(
  parameter int NEWTON_STEPS = cbe_pkg::DEF_NEWTON_STEPS,
  parameter int BISECT_STEPS = cbe_pkg::DEF_BISECT_STEPS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output cbe_pkg::dp_cmd_t  cmd,
  input  cbe_pkg::dp_stat_t stat
);
  import cbe_pkg::*;

  localparam int MAXI = (NEWTON_STEPS > BISECT_STEPS) ? NEWTON_STEPS : BISECT_STEPS;
  localparam int IW   = $clog2(MAXI + 1);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LOAD   = 8'b0000_0010,
    ST_NEVAL  = 8'b0000_0100,
    ST_NDIV   = 8'b0000_1000,
    ST_BISECT = 8'b0001_0000,
    ST_FINN   = 8'b0010_0000,
    ST_FINB   = 8'b0100_0000,
    ST_YEVAL  = 8'b1000_0000
  } state_t;

  state_t        state, state_next;
  logic [3:0]    uc, uc_next;
  logic [IW-1:0] iter, iter_next;

  // Curve evaluation steps shared by every evaluation phase.
  function automatic op_t eval_op(input logic [3:0] k);
    op_t r;
    case (k)
      4'd1:    r = OP_M_A;
      4'd2:    r = OP_M_B;
      4'd3:    r = OP_M_C;
      4'd4:    r = OP_M_B1;
      4'd5:    r = OP_M_B2;
      4'd6:    r = OP_M_B3;
      4'd7:    r = OP_M_P1;
      4'd8:    r = OP_M_P2;
      4'd9:    r = OP_SUM;
      default: r = OP_NOP;
    endcase
    return r;
  endfunction

  // Next state and command.
  always_comb begin
    state_next = state;
    uc_next    = uc;
    iter_next  = iter;
    cmd.op     = OP_NOP;
    cmd.sel_y  = (state == ST_YEVAL);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = ST_LOAD;
          uc_next    = '0;
          iter_next  = '0;
        end
      end
      ST_LOAD: begin
        if (stat.t_clamp) begin
          cmd.op     = OP_OUT;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_NEVAL;
        end
      end
      ST_NDIV: begin
        if (!stat.div_done) begin
          cmd.op = OP_DIV_STEP;
        end else begin
          cmd.op  = OP_NEWTON_UPD;
          uc_next = '0;
          if (iter == IW'(NEWTON_STEPS - 1)) begin
            iter_next  = '0;
            state_next = ST_BISECT;
          end else begin
            iter_next  = iter + 1'b1;
            state_next = ST_NEVAL;
          end
        end
      end
      ST_NEVAL, ST_BISECT, ST_FINN, ST_FINB, ST_YEVAL: begin
        uc_next = uc + 1'b1;
        if (uc == 4'd0) begin
          cmd.op = ((state == ST_BISECT) || (state == ST_FINB)) ? OP_EVAL_MID : OP_EVAL_S;
        end else if (uc < 4'd10) begin
          cmd.op = eval_op(uc);
        end else if (state == ST_NEVAL) begin
          // Slope terms, then either stop early or start the division.
          case (uc)
            4'd10: cmd.op = OP_M_D1;
            4'd11: cmd.op = OP_M_D2;
            4'd12: cmd.op = OP_M_D3;
            4'd13: cmd.op = OP_DSUM;
            default: begin
              uc_next = '0;
              if (stat.dx_zero) begin
                iter_next  = '0;
                state_next = ST_BISECT;
              end else begin
                cmd.op     = OP_DIV_START;
                state_next = ST_NDIV;
              end
            end
          endcase
        end else begin
          uc_next = '0;
          case (state)
            ST_BISECT: begin
              cmd.op = OP_BIS;
              if (iter == IW'(BISECT_STEPS - 1)) begin
                iter_next  = '0;
                state_next = ST_FINN;
              end else begin
                iter_next = iter + 1'b1;
              end
            end
            ST_FINN: begin
              cmd.op     = OP_SAVE_N;
              state_next = ST_FINB;
            end
            ST_FINB: begin
              cmd.op     = OP_PICK;
              state_next = ST_YEVAL;
            end
            default: begin
              cmd.op     = OP_OUT;
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      uc    <= '0;
      iter  <= '0;
    end else begin
      state <= state_next;
      uc    <= uc_next;
      iter  <= iter_next;
    end
  end

  assign busy = (state != ST_IDLE);

  // An accepted beat always makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted beat did not raise busy");

  // The divider is never stepped past its last quotient bit.
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_DIV_STEP |-> !stat.div_done) else $error("divider overrun");

  // Step counters stay within their loop bounds.
  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NDIV) |-> (iter < IW'(NEWTON_STEPS))) else $error("Newton count overrun");

  a_bis_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BISECT) |-> (iter < IW'(BISECT_STEPS))) else $error("bisection count overrun");

endmodule

[rtl/cubic_bezier_easing.sv]
// ----------------------------------------------------------------------------
// cubic_bezier_easing
// Cubic Bezier timing curve from (0,0) to (1,1) in fixed point. Holds the
// control point registers and joins the controller and the datapath.
//
//   channel   signals                                  direction
//   input     start, busy, progress                    start in, busy out
//   result    done, eased                              out, one cycle strobe
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data write channel
//
// A beat is taken when start is high and busy is low. A progress value at or
// outside [0,1] skips the solver: the load state goes straight to the output
// step. Otherwise the item runs the Newton steps, the bisection steps and the
// y evaluation on the one shared multiplier and the bit-serial divider of the
// Newton step, whose quotient has NW = 2*F+7 bits. Reset is synchronous and
// returns the control points to their defaults. The receiver cannot stall:
// each result appears for one cycle with done high.
// ----------------------------------------------------------------------------
module cubic_bezier_easing #(
  parameter int FRAC_BITS    = cbe_pkg::DEF_FRAC_BITS,
  parameter int NEWTON_STEPS = cbe_pkg::DEF_NEWTON_STEPS,
  parameter int BISECT_STEPS = cbe_pkg::DEF_BISECT_STEPS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [FRAC_BITS+2:0]       progress,
  output logic                              done,
  output logic signed [FRAC_BITS+2:0]       eased,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cbe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [FRAC_BITS+2:0]              cfg_data
);
  import cbe_pkg::*;

  localparam int XW = FRAC_BITS + 1;
  localparam int YW = FRAC_BITS + 3;
  localparam int ONE_I = 1 << FRAC_BITS;
  localparam int Y1_RST = (ONE_I + 5) / 10;

  logic [XW-1:0]        ctrl_x1, ctrl_x2;
  logic signed [YW-1:0] ctrl_y1, ctrl_y2;
  dp_cmd_t              cmd;
  dp_stat_t             stat;

  // Control point registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_x1 <= XW'(ONE_I >> 2);
      ctrl_y1 <= YW'(Y1_RST);
      ctrl_x2 <= XW'(ONE_I >> 2);
      ctrl_y2 <= YW'(ONE_I);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X1:  ctrl_x1 <= cfg_data[XW-1:0];
        REG_Y1:  ctrl_y1 <= $signed(cfg_data);
        REG_X2:  ctrl_x2 <= cfg_data[XW-1:0];
        REG_Y2:  ctrl_y2 <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  cbe_ctrl #(
    .NEWTON_STEPS (NEWTON_STEPS),
    .BISECT_STEPS (BISECT_STEPS)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Arithmetic.
  cbe_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .progress (progress),
    .ctrl_x1  (ctrl_x1),
    .ctrl_y1  (ctrl_y1),
    .ctrl_x2  (ctrl_x2),
    .ctrl_y2  (ctrl_y2),
    .eased    (eased),
    .done     (done)
  );

endmodule

[tb/cubic_bezier_easing_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cubic_bezier_easing_tb
// Self-checking bench for the cubic Bezier easing block. A fixed-point copy
// of the curve solver predicts each eased value; a small scoreboard checks
// the results in order while the control points are swept through several
// settings, extremes and out-of-range codes among them.
// ----------------------------------------------------------------------------
module cubic_bezier_easing_tb;
  import cbe_pkg::*;

  localparam int F = 16;
  localparam int W = F + 3;
  localparam int XW = F + 1;
  localparam longint ONE = 64'sd1 << F;
  localparam longint YLO = -2 * ONE;
  localparam longint YHI = 3 * ONE;
  localparam int NSTEPS = 8;
  localparam int BSTEPS = 16;
  localparam int LAT = 700;
  localparam longint LIMIT = 64'd3000000;
  // Register index that names no control point.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [W-1:0] progress = '0;
  logic done;
  logic signed [W-1:0] eased;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [W-1:0] cfg_data = '0;

  int errors = 0;
  longint cycles = 0;
  int sender_idle = 0;
  int items_sent = 0;

  // Control point copies as written to the block.
  logic [XW-1:0] cx1, cx2;
  logic [W-1:0] cy1, cy2;

  cubic_bezier_easing dut (.*);

  always #1 clk = ~clk;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // Fixed-point product, rounded to nearest, ties away from zero.
  function automatic longint qmul(longint a, longint b);
    longint ma, mb, r;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    r = (ma * mb + (64'sd1 <<< (F - 1))) >>> F;
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint bezier(longint s, longint p1, longint p2);
    longint inv;
    inv = ONE - s;
    return 3 * qmul(qmul(qmul(inv, inv), s), p1) + 3 * qmul(qmul(qmul(inv, s), s), p2)
           + qmul(qmul(s, s), s);
  endfunction

  function automatic longint lim(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Eased value for one progress code under the current control points.
  function automatic logic [W-1:0] ease_of(logic [W-1:0] code);
    longint t, x1, x2, y1, y2, s, inv, x, dx, lo, hi, mid, bis, res;
    t = longint'($signed(code));
    if (t <= 0) return '0;
    if (t >= ONE) return W'(ONE);
    x1 = lim(longint'(cx1), 0, ONE);
    x2 = lim(longint'(cx2), 0, ONE);
    y1 = lim(longint'($signed(cy1)), YLO, YHI);
    y2 = lim(longint'($signed(cy2)), YLO, YHI);
    s = t;
    for (int i = 0; i < NSTEPS; i++) begin
      inv = ONE - s;
      x = bezier(s, x1, x2);
      dx = 3 * qmul(qmul(inv, inv), x1) + 6 * qmul(qmul(inv, s), x2 - x1)
           + 3 * qmul(qmul(s, s), ONE - x2);
      if (dx == 0) break;
      s = lim(s - ((x - t) * ONE) / dx, 0, ONE);
    end
    lo = 0;
    hi = ONE;
    for (int i = 0; i < BSTEPS; i++) begin
      mid = (lo + hi) >>> 1;
      if (bezier(mid, x1, x2) < t) lo = mid;
      else hi = mid;
    end
    bis = (lo + hi) >>> 1;
    if (!(mag(bezier(s, x1, x2) - t) < mag(bezier(bis, x1, x2) - t))) s = bis;
    res = lim(bezier(s, y1, y2), YLO, YHI);
    return W'(res);
  endfunction

  class ease_board;
    logic [W-1:0] pending[$];
    logic [W-1:0] inputs[$];

    function void note_item(logic [W-1:0] code);
      pending.push_back(ease_of(code));
      inputs.push_back(code);
    endfunction

    task check_result(logic [W-1:0] got);
      logic [W-1:0] want, code;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result eased=%0d", $signed(got)));
        return;
      end
      want = pending.pop_front();
      code = inputs.pop_front();
      if (got !== want)
        report($sformatf("progress=%0d eased=%0d want %0d", $signed(code),
                         $signed(got), $signed(want)));
    endtask
  endclass

  ease_board board = new();

  // Sample accepted beats and results at the rising edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && start && !busy) board.note_item(progress);
    if (!rst && done) board.check_result(eased);
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_progress(input logic [W-1:0] code);
    while ($urandom_range(99) < sender_idle) @(negedge clk);
    start <= 1'b1;
    progress <= code;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start <= 1'b0;
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LAT) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_X1: cx1 = val[XW-1:0];
      REG_Y1: cy1 = val;
      REG_X2: cx2 = val[XW-1:0];
      REG_Y2: cy2 = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_curve(input longint x1, y1, x2, y2);
    write_reg(REG_X1, W'(x1));
    write_reg(REG_Y1, W'(y1));
    write_reg(REG_X2, W'(x2));
    write_reg(REG_Y2, W'(y2));
  endtask

  // Mostly interior progress values, some clamped, a few whole-range codes.
  function automatic logic [W-1:0] rand_progress();
    int k;
    k = $urandom_range(99);
    if (k < 80) return W'($urandom_range(int'(ONE) - 1, 1));
    if (k < 90) return W'(-longint'($urandom_range(int'(ONE))));
    if (k < 97) return W'(longint'($urandom_range(2 * int'(ONE), int'(ONE))));
    return W'($urandom);
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      send_progress(rand_progress());
    end
  endtask

  initial begin
    cx1 = XW'(ONE >> 2);
    cy1 = W'((ONE + 5) / 10);
    cx2 = XW'(ONE >> 2);
    cy2 = W'(ONE);
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Directed beats under the reset curve: bounds, clamps and edge codes.
    sender_idle = 0;
    send_progress(W'(0));
    send_progress(W'(1));
    send_progress(W'(32768));
    send_progress(W'(ONE - 1));
    send_progress(W'(ONE));
    send_progress(W'(2 * ONE));
    send_progress(W'(-1));
    send_progress(W'(-ONE));
    send_progress({1'b0, {(W - 1){1'b1}}});
    send_progress({1'b1, {(W - 1){1'b0}}});
    drain;

    // Flat-slope curve, y extremes and an unknown register index.
    set_curve(0, YLO, ONE, YHI);
    write_reg(REG_UNUSED, W'(12345));
    send_progress(W'(1));
    send_progress(W'(32768));
    send_progress(W'(ONE - 1));
    drain;
    // Out-of-range codes: x above one and y saturation.
    set_curve(2 * ONE - 1, {1'b0, {(W - 1){1'b1}}}, 2 * ONE - 1, {1'b1, {(W - 1){1'b0}}});
    send_progress(W'(16384));
    send_progress(W'(49152));
    drain;
    set_curve(ONE, YHI, 0, YHI);
    send_progress(W'(32768));
    send_progress(W'(20000));
    drain;

    // Random curves with three idling patterns.
    for (int ph = 0; ph < 12; ph++) begin
      sender_idle = ph < 4 ? 15 : (ph < 8 ? 55 : 0);
      set_curve($urandom_range(int'(ONE)), longint'($urandom_range(5 * int'(ONE))) + YLO,
                $urandom_range(int'(ONE)), longint'($urandom_range(5 * int'(ONE))) + YLO);
      random_phase(70);
      drain;
    end

    $display("sent %0d progress beats over 16 control point settings", items_sent);
    $display("covered clamped, interior, flat-slope and saturating cases");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
